// ===== rtl/lifo_pkg.sv =====
package lifo_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 4;
    localparam int COUNT_W = 4;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ===== rtl/lifo_ctrl.sv =====
module lifo_ctrl
    import lifo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_ready,
    output logic in_ready,
    output logic out_valid,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/lifo_dp.sv =====
module lifo_dp
    import lifo_pkg::*;
#(
    parameter int STACK_DEPTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  op_t                 func,
    input  logic [DATA_W-1:0]   value,
    input  logic [DEPTH_W-1:0]  depth,
    output logic [DATA_W-1:0]   data,
    output stat_t               status,
    output logic [COUNT_W-1:0]  count
);

    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CMPW = (CW > DEPTH_W) ? CW : DEPTH_W;

    logic [DATA_W-1:0]  mem [STACK_DEPTH];

    op_t                func_reg;
    logic [DATA_W-1:0]  value_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    stat_t              status_reg;
    stat_t              status_next;
    logic               rd_ok_reg;
    logic               rd_ok_next;
    logic [DATA_W-1:0]  rd_data_reg;

    logic               wr_en;
    logic [AW-1:0]      addr;
    logic               full;
    logic               empty;
    logic               depth_ok;
    logic [CMPW-1:0]    slot;

    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign empty    = (count_reg == '0);
    assign depth_ok = (depth_reg != '0) && (CMPW'(depth_reg) <= CMPW'(count_reg));
    assign slot     = CMPW'(count_reg) - CMPW'(depth_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= value;
            depth_reg <= depth;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        wr_en       = 1'b0;
        addr        = count_reg[AW-1:0];
        case (func_reg)
            OP_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    addr       = count_next[AW-1:0];
                    rd_ok_next = 1'b1;
                end
            end
            OP_READ, OP_WRITE:
            begin
                addr = slot[AW-1:0];
                if (!depth_ok)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else if (func_reg == OP_READ)
                begin
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_UNDERFLOW;
            end
        endcase
    end

    // single port: one write or one registered read per operation
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (wr_en)
            begin
                mem[addr] <= value_reg;
            end
            rd_data_reg <= mem[addr];
            status_reg  <= status_next;
            rd_ok_reg   <= rd_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign data   = rd_ok_reg ? rd_data_reg : '0;
    assign status = status_reg;
    assign count  = COUNT_W'(count_reg);

endmodule

// ===== rtl/lifo_stack_with_depth_access.sv =====
// Channel | Dir | tdata (low bit up)                      | tuser
// s_axis  | in  | value[31:0], depth[35:32], pad to 40    | func[1:0]
// m_axis  | out | data[31:0], count[35:32], pad to 40     | status[1:0]
//
// One operation at a time: accept in S_IDLE, the stack memory access in
// S_EXEC, then the result beat is offered in S_RESP and held there while
// m_axis_tready stays low. The single memory port with its registered read
// sets the S_EXEC step. Reset empties the stack (count zero); entries
// hold no reset value. s_axis_tready stays low until the result beat is taken.
module lifo_stack_with_depth_access
    import lifo_pkg::*;
#(
    parameter int STACK_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], depth[35:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // data[31:0], count[35:32], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    cmd_t               cmd;
    logic [DATA_W-1:0]  data;
    stat_t              status;
    logic [COUNT_W-1:0] count;

    lifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    lifo_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .func   (op_t'(s_axis_tuser)),
        .value  (s_axis_tdata[31:0]),
        .depth  (s_axis_tdata[35:32]),
        .data   (data),
        .status (status),
        .count  (count)
    );

    assign m_axis_tdata = {4'b0000, count, data};
    assign m_axis_tuser = status;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result beat is pending");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
        else $error("result beat not offered two cycles after accept");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[31:0] == '0))
        else $error("failed operation returned nonzero data");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OVERFLOW)
            |-> (m_axis_tdata[35:32] == COUNT_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");
`endif

endmodule
